[hw/rtl/sfe_pkg.sv]
// Package: shared types and constants for the STX/ETX frame encoder.
`timescale 1ns / 1ps

package sfe_pkg;

  localparam int BYTE_W    = 8;
  localparam int MAX_BYTES = 5;
  localparam int CNT_W     = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] STUFF_MASK    = 8'h20;
  localparam logic [BYTE_W-1:0] RST_START     = 8'd2;
  localparam logic [BYTE_W-1:0] RST_END       = 8'd3;
  localparam logic [BYTE_W-1:0] RST_ESCAPE    = 8'd27;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd2;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_delim;
    logic [BYTE_W-1:0] end_delim;
    logic [BYTE_W-1:0] escape;
  } cfg_t;

  // Up to five line bytes caused by one request, lowest entry sent first
  typedef struct packed {
    logic                             valid;
    logic [CNT_W-1:0]                 cnt;
    logic                             trailer;
    logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
  } burst_t;

endpackage

[hw/rtl/sfe_framer.sv]
// Framer: input register, frame state and the encode of one request into a burst.
`timescale 1ns / 1ps

module sfe_framer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,
  input  logic                  in_tuser,
  input  sfe_pkg::cfg_t         cfg,
  output sfe_pkg::burst_t       burst,
  input  logic                  burst_ready
);
  import sfe_pkg::*;

  logic              item_v_r;
  op_t               op_r;
  logic [BYTE_W-1:0] mtype_r, plen_r, data_r;

  logic              in_frame_r, in_frame_nxt;
  logic [BYTE_W-1:0] remaining_r, remaining_nxt;
  logic [BYTE_W-1:0] csum_r, csum_nxt;

  logic              take;
  logic              esc;
  logic              last;
  logic [BYTE_W-1:0] rem_dec;

  assign take      = item_v_r && burst_ready;
  assign in_tready = rst_n && (!item_v_r || burst_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_tready) begin
      item_v_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      op_r    <= op_t'(in_tuser);
      mtype_r <= in_tdata[7:0];
      plen_r  <= in_tdata[15:8];
      data_r  <= in_tdata[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      remaining_r <= '0;
      csum_r      <= '0;
    end else if (take) begin
      in_frame_r  <= in_frame_nxt;
      remaining_r <= remaining_nxt;
      csum_r      <= csum_nxt;
    end
  end

  assign esc     = (data_r == cfg.start_delim) || (data_r == cfg.end_delim) ||
                   (data_r == cfg.escape);
  assign rem_dec = remaining_r - 8'd1;
  assign last    = (rem_dec == '0);

  always_comb begin
    in_frame_nxt  = in_frame_r;
    remaining_nxt = remaining_r;
    csum_nxt      = csum_r;
    burst.valid   = item_v_r;
    burst.cnt     = '0;
    burst.trailer = 1'b0;
    burst.bytes   = '0;
    case (op_r)
      OP_START: begin
        csum_nxt       = '0;
        burst.bytes[0] = cfg.start_delim;
        burst.bytes[1] = mtype_r;
        burst.bytes[2] = plen_r;
        burst.bytes[3] = '0;
        burst.bytes[4] = cfg.end_delim;
        if (plen_r == '0) begin
          // Empty frame closes at once
          burst.cnt     = 3'd5;
          burst.trailer = 1'b1;
          in_frame_nxt  = 1'b0;
          remaining_nxt = '0;
        end else begin
          burst.cnt     = 3'd3;
          in_frame_nxt  = 1'b1;
          remaining_nxt = plen_r;
        end
      end
      default: begin
        if (in_frame_r) begin
          csum_nxt      = csum_r ^ data_r;
          remaining_nxt = rem_dec;
          if (esc) begin
            burst.bytes[0] = cfg.escape;
            burst.bytes[1] = data_r ^ STUFF_MASK;
            burst.bytes[2] = csum_nxt;
            burst.bytes[3] = cfg.end_delim;
            burst.cnt      = last ? 3'd4 : 3'd2;
          end else begin
            burst.bytes[0] = data_r;
            burst.bytes[1] = csum_nxt;
            burst.bytes[2] = cfg.end_delim;
            burst.cnt      = last ? 3'd3 : 3'd1;
          end
          if (last) begin
            burst.trailer = 1'b1;
            in_frame_nxt  = 1'b0;
          end
        end
      end
    endcase
  end

endmodule

[hw/rtl/sfe_serializer.sv]
// Serializer: holds one burst and sends it out a byte per cycle while out_tready is high.
`timescale 1ns / 1ps

module sfe_serializer (
  input  logic            clk,
  input  logic            rst_n,
  input  sfe_pkg::burst_t burst,
  output logic            burst_ready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [7:0]      out_tdata,
  output logic            out_tlast,
  output logic            out_tuser
);
  import sfe_pkg::*;

  logic                             bv_r;
  logic [CNT_W-1:0]                 left_r;
  logic                             trailer_r;
  logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes_r;
  logic                             final_byte;

  assign final_byte  = (left_r == 3'd1);
  assign burst_ready = !bv_r || (out_tready && final_byte);

  assign out_tvalid = bv_r;
  assign out_tdata  = bytes_r[0];
  assign out_tlast  = final_byte;
  assign out_tuser  = final_byte && trailer_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r   <= 1'b0;
      left_r <= '0;
    end else if (burst_ready) begin
      // Requests that cause no bytes are dropped here
      bv_r   <= burst.valid && (burst.cnt != '0);
      left_r <= burst.cnt;
    end else if (out_tready) begin
      left_r <= left_r - 3'd1;
    end
    if (burst_ready) begin
      bytes_r   <= burst.bytes;
      trailer_r <= burst.trailer;
    end else if (out_tready) begin
      bytes_r <= {BYTE_W'(0), bytes_r[MAX_BYTES-1:1]};
    end
  end

endmodule

[hw/rtl/stx_etx_frame_encoder.sv]
// Top level: STX/ETX frame encoder with byte stuffing and XOR checksum.
//
//  channel | ports                       | contents
//  --------+-----------------------------+------------------------------------------
//  in      | in_tvalid/tready/tdata/tuser| tdata: type byte, payload_length,
//          |                             |        data_byte; tuser: operation
//  out     | out_tvalid/tready/tdata/... | tdata: out_byte; tlast: run_last;
//          |                             | tuser: frame_done
//  cfg     | cfg_valid/ready/index/data  | 0 start, 1 end, 2 escape delimiter
//
// Each request yields 0 to 5 line bytes, sent one per cycle while out_tready is
// high: a start request gives 3 bytes (5 for an empty frame), a payload byte 1
// (2 when escaped) plus 2 for the closing checksum and end delimiter. The single
// output byte port sets this rate. An input register and a burst register part
// the two sides, so a new request is taken while the last byte of the previous
// one waits. Synchronous active-low reset clears the frame state and loads the
// default delimiters (2, 3, 27). Both ready outputs stay low while reset is
// held; out of reset, config writes are accepted in every cycle.
`timescale 1ns / 1ps

module stx_etx_frame_encoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [23:0] in_tdata,  // [7:0] type byte, [15:8] payload_length, [23:16] data_byte
  input  logic       in_tuser,   // [0] operation
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser,  // [0] frame_done
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import sfe_pkg::*;

  cfg_t   cfg_r;
  burst_t burst;
  logic   burst_ready;

  assign cfg_ready = rst_n;

  // Delimiter registers; index 3 is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_delim <= RST_START;
      cfg_r.end_delim   <= RST_END;
      cfg_r.escape      <= RST_ESCAPE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START:  cfg_r.start_delim <= cfg_data;
        CFG_END:    cfg_r.end_delim   <= cfg_data;
        CFG_ESCAPE: cfg_r.escape      <= cfg_data;
        default: ;
      endcase
    end
  end

  sfe_framer u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .cfg         (cfg_r),
    .burst       (burst),
    .burst_ready (burst_ready)
  );

  sfe_serializer u_serializer (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst       (burst),
    .burst_ready (burst_ready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for the STX/ETX frame encoder: scoreboard class plus stream drivers.
`timescale 1ns / 1ps

// Predicts the line bytes of every accepted request and checks them in order.
class frame_scoreboard;
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
  } line_byte_t;

  logic [7:0] stx;
  logic [7:0] etx;
  logic [7:0] esc;
  bit         frame_open;
  logic [7:0] bytes_left;
  logic [7:0] csum;
  line_byte_t due[$];
  int         errors;

  function new();
    stx        = sfe_pkg::RST_START;
    etx        = sfe_pkg::RST_END;
    esc        = sfe_pkg::RST_ESCAPE;
    frame_open = 1'b0;
    bytes_left = '0;
    csum       = '0;
    errors     = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [7:0] val);
    case (idx)
      sfe_pkg::CFG_START:  stx = val;
      sfe_pkg::CFG_END:    etx = val;
      sfe_pkg::CFG_ESCAPE: esc = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return due.size();
  endfunction

  function void push_byte(logic [7:0] b, logic done);
    line_byte_t e;
    e.data = b;
    e.last = 1'b0;
    e.done = done;
    due.push_back(e);
  endfunction

  // Checksum then end delimiter, neither stuffed
  function void close_frame();
    push_byte(csum, 1'b0);
    push_byte(etx, 1'b1);
    frame_open = 1'b0;
    bytes_left = '0;
  endfunction

  // Returns how many line bytes the request causes
  function int note_request(sfe_pkg::op_t op, logic [7:0] mtype, logic [7:0] plen,
                            logic [7:0] db);
    int before_cnt;
    before_cnt = due.size();
    if (op == sfe_pkg::OP_START) begin
      csum = '0;
      push_byte(stx, 1'b0);
      push_byte(mtype, 1'b0);
      push_byte(plen, 1'b0);
      if (plen == 8'd0) begin
        close_frame();
      end else begin
        frame_open = 1'b1;
        bytes_left = plen;
      end
    end else if (frame_open) begin
      csum = csum ^ db;
      if (db == stx || db == etx || db == esc) begin
        push_byte(esc, 1'b0);
        push_byte(db ^ sfe_pkg::STUFF_MASK, 1'b0);
      end else begin
        push_byte(db, 1'b0);
      end
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 8'd0) close_frame();
    end
    if (due.size() > before_cnt) due[due.size()-1].last = 1'b1;
    return due.size() - before_cnt;
  endfunction

  task report(string msg);
    if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_byte(logic [7:0] b, logic last, logic done);
    line_byte_t want;
    if (due.size() == 0) begin
      report($sformatf("unexpected byte %02h", b));
    end else begin
      want = due.pop_front();
      if (b !== want.data)
        report($sformatf("out_byte %02h, want %02h", b, want.data));
      if (last !== want.last)
        report($sformatf("run_last %b, want %b (byte %02h)", last, want.last, want.data));
      if (done !== want.done)
        report($sformatf("frame_done %b, want %b (byte %02h)", done, want.done, want.data));
    end
  endtask
endclass

module testbench;
  import sfe_pkg::*;

  // index 3 has no register behind it; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  logic        calm;          // no gaps and no stalls while set
  int          counted;       // requests that produced line bytes

  frame_scoreboard sb = new();

  stx_etx_frame_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: stalls about 38% of cycles unless in a calm stretch
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 38);
  end

  // Every accepted line byte goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_byte(out_tdata, out_tlast, out_tuser);
  end

  // Hard stop in case the block hangs or drops bytes
  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

  // One request on the input stream; random gaps ahead of it.
  // Returns at the accepting edge with in_tvalid still high.
  task send_req(op_t op, logic [7:0] mtype, logic [7:0] plen, logic [7:0] db);
    int n;
    while (!calm && $urandom_range(99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {db, plen, mtype};
    do @(posedge clk); while (!in_tready);
    n = sb.note_request(op, mtype, plen, db);
    if (n > 0) counted++;
  endtask

  // Sender goes quiet until every predicted byte is out, then lets the
  // pipeline settle (an ignored payload may still sit in the input stage)
  task wait_drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Leaves cfg_valid high; program_regs lowers it after the last write
  task write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task program_regs(logic [7:0] s, logic [7:0] e, logic [7:0] x);
    write_reg(CFG_START, s);
    write_reg(CFG_END, e);
    write_reg(CFG_ESCAPE, x);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Payload bytes lean hard on the delimiter values so stuffing is hit often
  function logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 15) return sb.stx;
    if (r < 30) return sb.etx;
    if (r < 45) return sb.esc;
    if (r < 50) return sb.esc ^ STUFF_MASK;
    return 8'($urandom);
  endfunction

  // Mostly short frames, some medium, a few long ones
  function int frame_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(5, 0);
    if (r < 95) return $urandom_range(24, 6);
    return $urandom_range(80, 25);
  endfunction

  // Start a frame announcing len bytes but send only sent of them
  task send_frame(int len, int sent);
    send_req(OP_START, 8'($urandom), 8'(len), 8'($urandom));
    repeat (sent) send_req(OP_PAYLOAD, 8'($urandom), 8'($urandom), pick_byte());
  endtask

  task random_phase(int target);
    int stop_at;
    int r;
    int len;
    stop_at = counted + target;
    while (counted < stop_at) begin
      r = $urandom_range(99);
      if (r < 10) begin
        // stray payload with no frame open: must produce nothing
        repeat ($urandom_range(3, 1))
          send_req(OP_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 22) begin
        // cut short, then abandoned by the next start
        len = $urandom_range(20, 2);
        send_frame(len, $urandom_range(len - 1, 0));
        len = frame_len();
        send_frame(len, len);
      end else begin
        len = frame_len();
        send_frame(len, len);
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_START;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    calm       <= 1'b0;
    counted    = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset delimiters 02/03/1B ---
    // empty frame: start, type, 0, checksum 0, end in one burst
    send_req(OP_START, 8'h00, 8'h00, 8'hFF);
    // stray payload, dropped
    send_req(OP_PAYLOAD, 8'hFF, 8'hFF, 8'h5A);
    // each delimiter value stuffed, plus an all-ones byte
    send_req(OP_START, 8'hFF, 8'h04, 8'h00);
    send_req(OP_PAYLOAD, 8'h00, 8'h00, 8'h02);
    send_req(OP_PAYLOAD, 8'hFF, 8'hFF, 8'h03);
    send_req(OP_PAYLOAD, 8'h00, 8'hFF, 8'h1B);
    send_req(OP_PAYLOAD, 8'hFF, 8'h00, 8'hFF);
    // longest length, abandoned after two bytes by a new start
    send_req(OP_START, 8'h81, 8'hFF, 8'h7E);
    send_req(OP_PAYLOAD, 8'h12, 8'h34, 8'h00);
    send_req(OP_PAYLOAD, 8'h56, 8'h78, 8'h22);
    send_req(OP_START, 8'h7E, 8'h01, 8'h1B);
    send_req(OP_PAYLOAD, 8'h00, 8'h00, 8'h1B);
    // sender holds off mid-frame until the line is empty
    send_req(OP_START, 8'h55, 8'h02, 8'hAA);
    send_req(OP_PAYLOAD, 8'hAA, 8'h55, 8'h03);
    wait_drain();
    send_req(OP_PAYLOAD, 8'h55, 8'hAA, 8'h00);
    // stray after a closed frame
    send_req(OP_PAYLOAD, 8'h00, 8'h00, 8'h02);
    random_phase(30);
    wait_drain();

    // --- extreme delimiters; the unmapped index must not land anywhere ---
    program_regs(8'h00, 8'hFF, 8'h80);
    write_reg(CFG_NONE, 8'h55);
    cfg_valid <= 1'b0;
    @(posedge clk);
    random_phase(25);
    wait_drain();

    // --- all three equal: any match is stuffed once; calm stretch here ---
    program_regs(8'hFF, 8'hFF, 8'hFF);
    calm <= 1'b1;
    random_phase(25);
    calm <= 1'b0;
    random_phase(5);
    wait_drain();

    // --- start and end equal, escape zero ---
    program_regs(8'h7E, 8'h7E, 8'h00);
    random_phase(25);
    wait_drain();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
